/* design/plb_pkg.sv */
// Shared types, codes and widths for the positional list buffer.
package plb_pkg;

    localparam int CAPACITY_DEF = 256;
    localparam int CAP_MAX      = 4096;
    localparam int CNT_W        = 13;   // holds any count up to CAP_MAX
    localparam int FUNC_W       = 3;
    localparam int POS_W        = 9;
    localparam int DATA_W       = 32;
    localparam int RES_W        = 40;
    localparam int STAT_W       = 3;

    // operation codes
    localparam logic [FUNC_W-1:0] FUNC_INSERT = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_DELETE = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_MIN    = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_MAX    = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_SUM    = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_SEARCH = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_SWAP   = 3'd6;

    // status codes
    localparam logic [STAT_W-1:0] STAT_OK       = 3'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY    = 3'd1;
    localparam logic [STAT_W-1:0] STAT_BADPOS   = 3'd2;
    localparam logic [STAT_W-1:0] STAT_FULL     = 3'd3;
    localparam logic [STAT_W-1:0] STAT_FEW      = 3'd4;
    localparam logic [STAT_W-1:0] STAT_NOTFOUND = 3'd5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_FILL,
        S_DONE
    } plb_state_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DELETE,
        CELL_ROTATE
    } cell_op_t;

    // broadcast command from the controller to every cell of the chain
    typedef struct packed {
        cell_op_t            op;
        logic [CNT_W-1:0]    idx;        // 0-based target slot
        logic [CNT_W-1:0]    count;      // entry count before the operation
        logic [DATA_W-1:0]   value;      // value to insert
        logic [DATA_W-1:0]   tail_data;  // value entering the tail on rotate
    } cell_cmd_t;

endpackage

/* design/plb_if.sv */
// Handshake channel interfaces for operation beats and result beats.
interface plb_in_if;
    logic                              valid;
    logic                              ready;
    logic [plb_pkg::FUNC_W-1:0]        func;
    logic [plb_pkg::POS_W-1:0]         position;
    logic signed [plb_pkg::DATA_W-1:0] value;

    modport source (output valid, func, position, value, input ready);
    modport sink   (input valid, func, position, value, output ready);
endinterface

interface plb_out_if;
    logic                              valid;
    logic                              ready;
    logic [plb_pkg::STAT_W-1:0]        status;
    logic signed [plb_pkg::RES_W-1:0]  result_value;
    logic [plb_pkg::POS_W-1:0]         found_position;
    logic [plb_pkg::POS_W-1:0]         entry_count;

    modport source (output valid, status, result_value, found_position, entry_count,
                    input ready);
    modport sink   (input valid, status, result_value, found_position, entry_count,
                    output ready);
endinterface

/* design/plb_cell.sv */
// One storage cell of the entry chain: holds one entry and trades it with its neighbors.
module plb_cell #(
    parameter int IDX = 0
) (
    input  logic                        clk,
    input  plb_pkg::cell_cmd_t          cmd,
    input  logic [plb_pkg::DATA_W-1:0]  left_data,
    input  logic [plb_pkg::DATA_W-1:0]  right_data,
    output logic [plb_pkg::DATA_W-1:0]  data
);

    localparam logic [plb_pkg::CNT_W-1:0] MY_IDX  = plb_pkg::CNT_W'(IDX);
    localparam logic [plb_pkg::CNT_W-1:0] MY_NEXT = plb_pkg::CNT_W'(IDX + 1);

    logic [plb_pkg::DATA_W-1:0] data_reg;
    logic [plb_pkg::DATA_W-1:0] data_next;

    // pick the new entry from the command and the neighbors
    always_comb
    begin
        data_next = data_reg;
        case (cmd.op)
            plb_pkg::CELL_INSERT:
            begin
                if (MY_IDX == cmd.idx)
                    data_next = cmd.value;
                else if (MY_IDX > cmd.idx && MY_IDX <= cmd.count)
                    data_next = left_data;
            end
            plb_pkg::CELL_DELETE:
            begin
                if (MY_IDX >= cmd.idx && MY_NEXT < cmd.count)
                    data_next = right_data;
            end
            plb_pkg::CELL_ROTATE:
            begin
                if (MY_NEXT < cmd.count)
                    data_next = right_data;
                else if (MY_NEXT == cmd.count)
                    data_next = cmd.tail_data;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    // hold the entry
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

/* design/plb_ctrl.sv */
// Sequencer: decodes operation beats, drives the cell chain and reduces the rotating head.
module plb_ctrl #(
    parameter int CAPACITY = plb_pkg::CAPACITY_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    plb_in_if.sink                      cmd,
    plb_out_if.source                   rsp,
    input  logic [plb_pkg::DATA_W-1:0]  head_data,
    output plb_pkg::cell_cmd_t          cell_cmd
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);
    localparam int PW = plb_pkg::CNT_W + 1;
    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

    plb_pkg::plb_state_t state_reg, state_next;

    logic [plb_pkg::FUNC_W-1:0]        func_reg, func_next;
    logic [plb_pkg::POS_W-1:0]         pos_reg, pos_next;
    logic [plb_pkg::DATA_W-1:0]        value_reg, value_next;
    logic [CW-1:0]                     count_reg, count_next;
    logic [IW-1:0]                     step_reg, step_next;
    logic [plb_pkg::STAT_W-1:0]        status_reg, status_next;
    logic signed [plb_pkg::RES_W-1:0]  acc_reg, acc_next;
    logic [CW-1:0]                     found_reg, found_next;
    logic                              hit_reg, hit_next;
    logic [plb_pkg::DATA_W-1:0]        first_reg, first_next;
    logic [plb_pkg::DATA_W-1:0]        last_reg, last_next;

    logic                              out_valid_reg, out_valid_next;
    logic [plb_pkg::STAT_W-1:0]        out_status_reg, out_status_next;
    logic signed [plb_pkg::RES_W-1:0]  out_result_reg, out_result_next;
    logic [plb_pkg::POS_W-1:0]         out_found_reg, out_found_next;
    logic [plb_pkg::POS_W-1:0]         out_count_reg, out_count_next;

    logic                              is_empty;
    logic                              last_step;
    logic                              insert_ok;
    logic                              delete_ok;
    logic                              slot_free;
    logic [PW-1:0]                     pos_w;
    logic [PW-1:0]                     cnt_w;
    logic signed [plb_pkg::RES_W-1:0]  head_sx;

    // shared decode
    assign is_empty  = (count_reg == '0);
    assign last_step = (CW'(step_reg) == count_reg - CW'(1));
    assign pos_w     = PW'(pos_reg);
    assign cnt_w     = PW'(count_reg);
    assign insert_ok = (count_reg < CAP_CNT) && (pos_w != '0) && (pos_w <= cnt_w + PW'(1));
    assign delete_ok = !is_empty && (pos_w != '0) && (pos_w <= cnt_w);
    assign slot_free = !out_valid_reg || rsp.ready;
    assign head_sx   = {{(plb_pkg::RES_W - plb_pkg::DATA_W){head_data[plb_pkg::DATA_W-1]}},
                        head_data};

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            plb_pkg::S_IDLE:
            begin
                if (cmd.valid)
                    state_next = plb_pkg::S_EXEC;
            end
            plb_pkg::S_EXEC:
            begin
                case (func_reg)
                    plb_pkg::FUNC_MIN, plb_pkg::FUNC_MAX, plb_pkg::FUNC_SUM,
                    plb_pkg::FUNC_SEARCH:
                        state_next = is_empty ? plb_pkg::S_DONE : plb_pkg::S_SCAN;
                    plb_pkg::FUNC_SWAP:
                        state_next = (count_reg > CW'(1)) ? plb_pkg::S_SCAN : plb_pkg::S_DONE;
                    default:
                        state_next = plb_pkg::S_DONE;
                endcase
            end
            plb_pkg::S_SCAN:
            begin
                if (last_step)
                    state_next = (func_reg == plb_pkg::FUNC_SWAP) ? plb_pkg::S_FILL
                                                                  : plb_pkg::S_DONE;
            end
            plb_pkg::S_FILL:
            begin
                if (last_step)
                    state_next = plb_pkg::S_DONE;
            end
            plb_pkg::S_DONE:
            begin
                if (slot_free)
                    state_next = plb_pkg::S_IDLE;
            end
            default:
            begin
                state_next = plb_pkg::S_IDLE;
            end
        endcase
    end

    // outputs: handshake and chain command
    always_comb
    begin
        cmd.ready          = (state_reg == plb_pkg::S_IDLE);
        cell_cmd.op        = plb_pkg::CELL_HOLD;
        cell_cmd.idx       = plb_pkg::CNT_W'(pos_reg) - plb_pkg::CNT_W'(1);
        cell_cmd.count     = plb_pkg::CNT_W'(count_reg);
        cell_cmd.value     = value_reg;
        cell_cmd.tail_data = head_data;
        case (state_reg)
            plb_pkg::S_EXEC:
            begin
                if (func_reg == plb_pkg::FUNC_INSERT && insert_ok)
                    cell_cmd.op = plb_pkg::CELL_INSERT;
                else if (func_reg == plb_pkg::FUNC_DELETE && delete_ok)
                    cell_cmd.op = plb_pkg::CELL_DELETE;
            end
            plb_pkg::S_SCAN:
            begin
                cell_cmd.op = plb_pkg::CELL_ROTATE;
            end
            plb_pkg::S_FILL:
            begin
                // second lap: old last goes to the front, old first to the back
                cell_cmd.op = plb_pkg::CELL_ROTATE;
                if (step_reg == '0)
                    cell_cmd.tail_data = last_reg;
                else if (last_step)
                    cell_cmd.tail_data = first_reg;
            end
            default:
            begin
                cell_cmd.op = plb_pkg::CELL_HOLD;
            end
        endcase
    end

    // datapath and result registers
    always_comb
    begin
        func_next       = func_reg;
        pos_next        = pos_reg;
        value_next      = value_reg;
        count_next      = count_reg;
        step_next       = step_reg;
        status_next     = status_reg;
        acc_next        = acc_reg;
        found_next      = found_reg;
        hit_next        = hit_reg;
        first_next      = first_reg;
        last_next       = last_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_result_next = out_result_reg;
        out_found_next  = out_found_reg;
        out_count_next  = out_count_reg;

        // drop a result once taken
        if (out_valid_reg && rsp.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            plb_pkg::S_IDLE:
            begin
                if (cmd.valid)
                begin
                    func_next  = cmd.func;
                    pos_next   = cmd.position;
                    value_next = cmd.value;
                end
            end
            plb_pkg::S_EXEC:
            begin
                step_next   = '0;
                acc_next    = '0;
                found_next  = '0;
                hit_next    = 1'b0;
                status_next = plb_pkg::STAT_OK;
                case (func_reg)
                    plb_pkg::FUNC_INSERT:
                    begin
                        if (count_reg >= CAP_CNT)
                            status_next = plb_pkg::STAT_FULL;
                        else if (!insert_ok)
                            status_next = plb_pkg::STAT_BADPOS;
                        else
                            count_next = count_reg + CW'(1);
                    end
                    plb_pkg::FUNC_DELETE:
                    begin
                        if (is_empty)
                            status_next = plb_pkg::STAT_EMPTY;
                        else if (!delete_ok)
                            status_next = plb_pkg::STAT_BADPOS;
                        else
                            count_next = count_reg - CW'(1);
                    end
                    plb_pkg::FUNC_MIN, plb_pkg::FUNC_MAX:
                    begin
                        if (is_empty)
                            status_next = plb_pkg::STAT_EMPTY;
                    end
                    plb_pkg::FUNC_SEARCH:
                    begin
                        status_next = is_empty ? plb_pkg::STAT_EMPTY : plb_pkg::STAT_NOTFOUND;
                    end
                    plb_pkg::FUNC_SWAP:
                    begin
                        if (is_empty)
                            status_next = plb_pkg::STAT_EMPTY;
                        else if (count_reg == CW'(1))
                            status_next = plb_pkg::STAT_FEW;
                    end
                    default:
                    begin
                        status_next = plb_pkg::STAT_OK;
                    end
                endcase
            end
            plb_pkg::S_SCAN:
            begin
                // reduce the entry now at the head of the ring
                step_next = last_step ? '0 : step_reg + IW'(1);
                case (func_reg)
                    plb_pkg::FUNC_MIN:
                    begin
                        if (step_reg == '0 || head_sx < acc_reg)
                            acc_next = head_sx;
                    end
                    plb_pkg::FUNC_MAX:
                    begin
                        if (step_reg == '0 || head_sx > acc_reg)
                            acc_next = head_sx;
                    end
                    plb_pkg::FUNC_SUM:
                    begin
                        acc_next = acc_reg + head_sx;
                    end
                    plb_pkg::FUNC_SEARCH:
                    begin
                        if (!hit_reg && head_data == value_reg)
                        begin
                            hit_next    = 1'b1;
                            found_next  = CW'(step_reg) + CW'(1);
                            status_next = plb_pkg::STAT_OK;
                        end
                    end
                    plb_pkg::FUNC_SWAP:
                    begin
                        if (step_reg == '0)
                            first_next = head_data;
                        if (last_step)
                            last_next = head_data;
                    end
                    default:
                    begin
                        acc_next = acc_reg;
                    end
                endcase
            end
            plb_pkg::S_FILL:
            begin
                step_next = last_step ? '0 : step_reg + IW'(1);
            end
            plb_pkg::S_DONE:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_result_next = acc_reg;
                    out_found_next  = plb_pkg::POS_W'(found_reg);
                    out_count_next  = plb_pkg::POS_W'(count_reg);
                end
            end
            default:
            begin
                step_next = step_reg;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= plb_pkg::S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        pos_reg        <= pos_next;
        value_reg      <= value_next;
        step_reg       <= step_next;
        status_reg     <= status_next;
        acc_reg        <= acc_next;
        found_reg      <= found_next;
        hit_reg        <= hit_next;
        first_reg      <= first_next;
        last_reg       <= last_next;
        out_status_reg <= out_status_next;
        out_result_reg <= out_result_next;
        out_found_reg  <= out_found_next;
        out_count_reg  <= out_count_next;
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.result_value   = out_result_reg;
    assign rsp.found_position = out_found_reg;
    assign rsp.entry_count    = out_count_reg;

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_CNT)
        else $error("entry count above capacity");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready) |=> (state_reg == plb_pkg::S_EXEC))
        else $error("accepted beat not decoded");

    a_count_only_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != plb_pkg::S_EXEC) |=> $stable(count_reg))
        else $error("entry count changed outside decode");

    a_lap_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == plb_pkg::S_SCAN || state_reg == plb_pkg::S_FILL)
            |-> (count_reg != '0 && CW'(step_reg) < count_reg))
        else $error("ring step beyond entry count");

    a_fill_swap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == plb_pkg::S_FILL) |-> (func_reg == plb_pkg::FUNC_SWAP && count_reg > CW'(1)))
        else $error("rewrite lap without a valid swap");

endmodule

/* design/positional_list_buffer.sv */
// Insert, delete, error and unused codes: decode state, then done state, which loads the result.
// Min, max, sum and search put a scan lap between them; swap puts a scan lap and a rewrite lap.
// One operation at a time: the next beat is taken in the cycle after the result is loaded.
// The scan rate is one entry a cycle, set by the ring of cells rotating its entries past cell 0.
// Reset clears the entry count, sequencer and result valid; stored entries need no clearing.
module positional_list_buffer #(
    parameter int CAPACITY = plb_pkg::CAPACITY_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    plb_in_if.sink     cmd,
    plb_out_if.source  rsp
);

    logic [plb_pkg::DATA_W-1:0] cell_q [CAPACITY];
    plb_pkg::cell_cmd_t         cell_cmd;

    // sequencer and reducer
    plb_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .rsp       (rsp),
        .head_data (cell_q[0]),
        .cell_cmd  (cell_cmd)
    );

    // chain of entry cells, position 1 at cell 0
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic [plb_pkg::DATA_W-1:0] left_d;
        logic [plb_pkg::DATA_W-1:0] right_d;

        if (g == 0)
        begin : g_first
            assign left_d = '0;
        end
        else
        begin : g_mid_l
            assign left_d = cell_q[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_last
            assign right_d = '0;
        end
        else
        begin : g_mid_r
            assign right_d = cell_q[g+1];
        end

        plb_cell #(
            .IDX (g)
        ) u_cell (
            .clk        (clk),
            .cmd        (cell_cmd),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (cell_q[g])
        );
    end

endmodule

/* bench/plb_list_checker.sv */
// Checker that mirrors the list contents and scores every reply beat of the list buffer.
`timescale 1ns / 100ps
module plb_list_checker #(
    parameter int CAPACITY = plb_pkg::CAPACITY_DEF
) (
    input  logic clk,
    input  logic rst_n,
    plb_in_if    cmd,
    plb_out_if   rsp,
    output int   errors,
    output int   pending,
    output int   results_seen
);
    import plb_pkg::*;

    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic signed [RES_W-1:0]  result_value;
        logic [POS_W-1:0]         found_position;
        logic [POS_W-1:0]         entry_count;
    } list_reply_t;

    // mirror of the stored sequence, head first
    logic signed [DATA_W-1:0] contents[$];
    list_reply_t              replies_due[$];

    int mismatches      = 0;
    int replies_checked = 0;
    int owed            = 0;

    assign errors       = mismatches;
    assign pending      = owed;
    assign results_seen = replies_checked;

    // print one line per failure and count it
    task automatic note_failure(input string msg);
        $display("%0d ns: %s", $time, msg);
        mismatches++;
    endtask

    // apply one operation to the mirror and return the reply it owes
    function automatic list_reply_t apply_list_op(
        input logic [FUNC_W-1:0]        op,
        input logic [POS_W-1:0]         pos,
        input logic signed [DATA_W-1:0] val
    );
        list_reply_t              r;
        int                       n;
        logic signed [RES_W-1:0]  acc;
        logic signed [DATA_W-1:0] t;
        r = '0;
        r.status = STAT_OK;
        n = contents.size();
        acc = '0;
        case (op)
            FUNC_INSERT:
            begin
                // a full store wins over a bad position
                if (n >= CAPACITY)
                    r.status = STAT_FULL;
                else if (pos < 1 || pos > n + 1)
                    r.status = STAT_BADPOS;
                else
                    contents.insert(int'(pos) - 1, val);
            end
            FUNC_DELETE:
            begin
                if (n == 0)
                    r.status = STAT_EMPTY;
                else if (pos < 1 || pos > n)
                    r.status = STAT_BADPOS;
                else
                    contents.delete(int'(pos) - 1);
            end
            FUNC_MIN, FUNC_MAX:
            begin
                if (n == 0)
                    r.status = STAT_EMPTY;
                else
                begin
                    acc = contents[0];
                    for (int i = 1; i < n; i++)
                        if ((op == FUNC_MIN) ? (contents[i] < acc) : (contents[i] > acc))
                            acc = contents[i];
                    r.result_value = acc;
                end
            end
            FUNC_SUM:
            begin
                // an empty store sums to zero with ok status
                for (int i = 0; i < n; i++)
                    acc += contents[i];
                r.result_value = acc;
            end
            FUNC_SEARCH:
            begin
                if (n == 0)
                    r.status = STAT_EMPTY;
                else
                begin
                    // stop at the first match
                    r.status = STAT_NOTFOUND;
                    for (int i = 0; i < n && r.status != STAT_OK; i++)
                        if (contents[i] == val)
                        begin
                            r.found_position = POS_W'(i + 1);
                            r.status = STAT_OK;
                        end
                end
            end
            FUNC_SWAP:
            begin
                if (n == 0)
                    r.status = STAT_EMPTY;
                else if (n == 1)
                    r.status = STAT_FEW;
                else
                begin
                    t = contents[0];
                    contents[0] = contents[n - 1];
                    contents[n - 1] = t;
                end
            end
            default:
            begin
                // spare code: no change, zero fields
            end
        endcase
        r.entry_count = POS_W'(contents.size());
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        list_reply_t got;
        list_reply_t want;
        if (!rst_n)
        begin
            contents.delete();
            replies_due.delete();
            owed <= 0;
        end
        else
        begin
            // score the reply beat against the oldest owed reply
            if (rsp.valid && rsp.ready)
            begin
                got.status         = rsp.status;
                got.result_value   = rsp.result_value;
                got.found_position = rsp.found_position;
                got.entry_count    = rsp.entry_count;
                replies_checked++;
                if (replies_due.size() == 0)
                    note_failure($sformatf("reply beat with nothing owed: status %0d count %0d",
                                           got.status, got.entry_count));
                else
                begin
                    want = replies_due.pop_front();
                    if (got.status !== want.status)
                        note_failure($sformatf("status %0d, expected %0d",
                                               got.status, want.status));
                    if (got.result_value !== want.result_value)
                        note_failure($sformatf("result_value %0d, expected %0d",
                                               got.result_value, want.result_value));
                    if (got.found_position !== want.found_position)
                        note_failure($sformatf("found_position %0d, expected %0d",
                                               got.found_position, want.found_position));
                    if (got.entry_count !== want.entry_count)
                        note_failure($sformatf("entry_count %0d, expected %0d",
                                               got.entry_count, want.entry_count));
                end
            end
            // mirror the accepted operation beat
            if (cmd.valid && cmd.ready)
                replies_due.push_back(apply_list_op(cmd.func, cmd.position, cmd.value));
            owed <= replies_due.size();
        end
    end

endmodule

/* bench/tb_positional_list_buffer.sv */
// Top of the list buffer bench: clock, reset, operation stimulus, reply pacing and verdict.
`timescale 1ns / 100ps
module tb_positional_list_buffer;
    import plb_pkg::*;

    localparam int                 CAPACITY    = CAPACITY_DEF;
    localparam logic [FUNC_W-1:0]  FUNC_SPARE  = 3'd7;
    localparam int                 SCAN_CYCLES = 2 * CAPACITY + 8;
    localparam int                 CYCLE_LIMIT = 5_000_000;
    localparam int                 HOLD_START  = 2500;
    localparam int                 LONG_HOLD   = 400;
    localparam logic signed [DATA_W-1:0] INT_MAX_V = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] INT_MIN_V = 32'sh8000_0000;

    logic clk = 1'b0;
    logic rst_n;

    plb_in_if  cmd_bus ();
    plb_out_if rsp_bus ();

    int fail_count;
    int owed;
    int checked;

    positional_list_buffer #(.CAPACITY(CAPACITY)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .rsp   (rsp_bus)
    );

    plb_list_checker #(.CAPACITY(CAPACITY)) chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd_bus),
        .rsp          (rsp_bus),
        .errors       (fail_count),
        .pending      (owed),
        .results_seen (checked)
    );

    always #5 clk = ~clk;

    initial
    begin
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    // rough fill level, used to aim positions and to track the peak fill
    int stored = 0;
    int peak = 0;
    int beats_sent = 0;
    int op_tally[8];
    bit calm = 1'b0;
    bit choppy = 1'b1;
    logic signed [DATA_W-1:0] recent[16];
    int recent_wr = 0;
    int cycle_count = 0;

    // end the run if the block hangs
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    // pace reply beats: short random stalls, one long hold-off, none at the end
    initial
    begin
        int  quiet;
        int  cyc;
        bit  chop;
        bit  held;
        quiet = 0;
        cyc = 0;
        chop = 1'b1;
        held = 1'b0;
        rsp_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (cyc % 64 == 0)
                chop = $urandom_range(0, 1);
            if (quiet > 0)
                quiet--;
            else if (!held && cyc >= HOLD_START)
            begin
                quiet = LONG_HOLD;
                held = 1'b1;
            end
            else if (!calm && chop && $urandom_range(0, 4) == 0)
                quiet = $urandom_range(1, 7);
            rsp_bus.ready <= (quiet == 0);
        end
    end

    // offer one operation beat and hold it until taken
    task automatic issue(input logic [FUNC_W-1:0] f, input logic [POS_W-1:0] p,
                         input logic signed [DATA_W-1:0] v);
        int gap;
        if (!calm && choppy && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 7);
            cmd_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_bus.valid    <= 1'b1;
        cmd_bus.func     <= f;
        cmd_bus.position <= p;
        cmd_bus.value    <= v;
        @(posedge clk);
        while (!cmd_bus.ready)
            @(posedge clk);
        beats_sent++;
        op_tally[f]++;
        if (f == FUNC_INSERT && stored < CAPACITY && p >= 1 && p <= stored + 1)
            stored++;
        else if (f == FUNC_DELETE && stored > 0 && p >= 1 && p <= stored)
            stored--;
        if (stored > peak)
            peak = stored;
        if (beats_sent % 40 == 0)
            choppy = $urandom_range(0, 1);
    endtask

    function automatic logic signed [DATA_W-1:0] any_value();
        logic signed [DATA_W-1:0] v;
        case ($urandom_range(0, 7))
            0, 1, 2: v = $urandom;
            3, 4:    v = $urandom_range(0, 6) - 3;
            5:       v = INT_MAX_V;
            6:       v = INT_MIN_V;
            default: v = $urandom_range(0, 1) ? 32'sd0 : -32'sd1;
        endcase
        return v;
    endfunction

    // one random operation; grow_pct steers insert against delete,
    // bias_pct forces inserted values to bias_v
    task automatic random_op(input int grow_pct, input int bias_pct,
                             input logic signed [DATA_W-1:0] bias_v);
        logic [FUNC_W-1:0]        f;
        logic [POS_W-1:0]         p;
        logic signed [DATA_W-1:0] v;
        p = POS_W'($urandom_range(0, 511));
        v = any_value();
        if ($urandom_range(0, 99) < 75)
        begin
            if ($urandom_range(0, 99) < grow_pct)
            begin
                f = FUNC_INSERT;
                if ($urandom_range(0, 99) < 93)
                    p = POS_W'($urandom_range(1, stored + 1));
                if ($urandom_range(0, 99) < bias_pct)
                    v = bias_v;
                recent[recent_wr] = v;
                recent_wr = (recent_wr + 1) % 16;
            end
            else
            begin
                f = FUNC_DELETE;
                if (stored > 0 && $urandom_range(0, 99) < 93)
                    p = POS_W'($urandom_range(1, stored));
            end
        end
        else
        begin
            case ($urandom_range(0, 10))
                0, 1:    f = FUNC_MIN;
                2, 3:    f = FUNC_MAX;
                4, 5:    f = FUNC_SUM;
                6, 7, 8: f = FUNC_SEARCH;
                9:       f = FUNC_SWAP;
                default: f = FUNC_SPARE;
            endcase
            // search half the time for recently inserted values
            if (f == FUNC_SEARCH && $urandom_range(0, 1) == 1)
                v = recent[$urandom_range(0, 15)];
        end
        issue(f, p, v);
    endtask

    initial
    begin
        cmd_bus.valid    <= 1'b0;
        cmd_bus.func     <= FUNC_INSERT;
        cmd_bus.position <= '0;
        cmd_bus.value    <= '0;
        foreach (recent[i])
            recent[i] = '0;
        foreach (op_tally[i])
            op_tally[i] = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);

        // empty store: each reduce, search, swap and delete
        issue(FUNC_MIN, 9'd0, 32'sd0);
        issue(FUNC_MAX, 9'd0, 32'sd0);
        issue(FUNC_SUM, 9'd0, 32'sd0);
        issue(FUNC_SEARCH, 9'd1, 32'sd0);
        issue(FUNC_SWAP, 9'd0, 32'sd0);
        issue(FUNC_DELETE, 9'd1, 32'sd0);
        // insert positions out of range, then a single entry
        issue(FUNC_INSERT, 9'd0, 32'sd5);
        issue(FUNC_INSERT, 9'd2, 32'sd5);
        issue(FUNC_INSERT, 9'd1, INT_MIN_V);
        issue(FUNC_SWAP, 9'd0, 32'sd0);
        // append, head and middle inserts: -1, 0, min, max
        issue(FUNC_INSERT, 9'd2, INT_MAX_V);
        issue(FUNC_INSERT, 9'd1, -32'sd1);
        issue(FUNC_INSERT, 9'd2, 32'sd0);
        issue(FUNC_INSERT, 9'd511, 32'sd7);
        issue(FUNC_MIN, 9'd511, 32'sd0);
        issue(FUNC_MAX, 9'd0, 32'sd0);
        issue(FUNC_SUM, 9'd0, 32'sd0);
        issue(FUNC_SEARCH, 9'd0, INT_MAX_V);
        issue(FUNC_SEARCH, 9'd0, 32'sd12345);
        issue(FUNC_SWAP, 9'd0, 32'sd0);
        issue(FUNC_SEARCH, 9'd0, -32'sd1);
        // delete out of range, at the tail, at the head
        issue(FUNC_DELETE, 9'd0, 32'sd0);
        issue(FUNC_DELETE, 9'd5, 32'sd0);
        issue(FUNC_DELETE, 9'd4, 32'sd0);
        issue(FUNC_SPARE, 9'd3, 32'sd9);
        issue(FUNC_DELETE, 9'd1, 32'sd0);

        // fill to capacity with many top values, then push on a full store
        repeat (500) random_op(92, 40, INT_MAX_V);
        // drain to empty and keep hitting the empty store
        repeat (450) random_op(8, 0, 32'sd0);
        // refill with bottom values to reach the most negative sum
        repeat (450) random_op(95, 100, INT_MIN_V);
        repeat (350) random_op(40, 10, INT_MAX_V);
        // last stretch at full rate on both sides
        calm = 1'b1;
        repeat (150) random_op(50, 0, 32'sd0);
        cmd_bus.valid <= 1'b0;

        // wait out the owed replies, then watch for strays
        @(posedge clk);
        while (owed != 0)
            @(posedge clk);
        repeat (SCAN_CYCLES) @(posedge clk);

        $display("%0d ops: %0d insert, %0d delete, %0d reduce, %0d search, %0d swap, %0d spare",
                 beats_sent, op_tally[FUNC_INSERT], op_tally[FUNC_DELETE],
                 op_tally[FUNC_MIN] + op_tally[FUNC_MAX] + op_tally[FUNC_SUM],
                 op_tally[FUNC_SEARCH], op_tally[FUNC_SWAP], op_tally[FUNC_SPARE]);
        $display("store reached %0d of %0d entries; %0d replies compared, %0d failures",
                 peak, CAPACITY, checked, fail_count);
        if (fail_count == 0 && owed == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
